// ===== sv/pcps_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the chamber pressure step block.
// No dependencies; imported by pcps_valve_lane and the top level.
package pcps_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_CRITICAL_RATIO      = 3'd0;
    localparam logic [2:0] CFG_FLOW_COEFFICIENT    = 3'd1;
    localparam logic [2:0] CFG_CHAMBER_GAIN        = 3'd2;
    localparam logic [2:0] CFG_SUPPLY_PRESSURE     = 3'd3;
    localparam logic [2:0] CFG_ATMOSPHERE_PRESSURE = 3'd4;
    localparam logic [2:0] CFG_INITIAL_PRESSURE    = 3'd5;

    localparam int CFG_DATA_BITS = 20;
    localparam int TERM_BITS     = 48;

    // Q16 full-open value for valve openings
    localparam logic [16:0] Q16_ONE = 17'h10000;

    typedef struct packed {
        logic [16:0] inlet_opening;
        logic [16:0] outlet_opening;
    } t_in_beat;

    typedef struct packed {
        logic [19:0] chamber_pressure_out;
        logic        pressure_clipped;
    } t_out_beat;

    // lane status handed to the merge stage
    typedef struct packed {
        logic                 done;
        logic [TERM_BITS-1:0] term;
    } t_lane_res;

endpackage

// ===== sv/pcps_valve_lane.sv =====
`timescale 1ns / 1ps
// One valve lane: ratio divide, subsonic divide, integer square root and
// the flow and opening scaling, run on a small sequencer. Uses pcps_pkg.
module pcps_valve_lane #(
    parameter int UP_BITS = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [UP_BITS-1:0]  i_up,
    input  logic [UP_BITS-1:0]  i_down,
    input  logic [16:0]         i_open,
    input  logic [15:0]         i_crit,
    input  logic [15:0]         i_coef,
    output pcps_pkg::t_lane_res o_res
);
    import pcps_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIVR = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_DIVX = 4'd3;
    localparam logic [3:0] S_SQR  = 4'd4;
    localparam logic [3:0] S_ROOT = 4'd5;
    localparam logic [3:0] S_MFS  = 4'd6;
    localparam logic [3:0] S_MUP  = 4'd7;
    localparam logic [3:0] S_MOP  = 4'd8;
    localparam logic [3:0] S_SUM  = 4'd9;

    logic [3:0]           r_state;
    logic [3:0]           r_cnt;
    logic                 r_done;
    logic [UP_BITS-1:0]   r_up;
    logic [UP_BITS-1:0]   r_den;
    logic [UP_BITS-1:0]   r_rem;
    logic [15:0]          r_q;
    logic [31:0]          r_sq;
    logic [31:0]          r_res;
    logic [31:0]          r_fs;
    logic [47:0]          r_f;
    logic [48:0]          r_p1;
    logic [32:0]          r_p0;
    logic [47:0]          r_t;
    logic [16:0]          r_open;

    logic [UP_BITS:0]     rem2;
    logic                 ge;
    logic [UP_BITS:0]     rem_diff;
    logic [31:0]          sq_bit;
    logic [31:0]          trial;
    logic [UP_BITS+31:0]  mup;
    logic [16:0]          open_sat;

    // restoring divide step and square root step
    always_comb begin
        rem2     = {r_rem, 1'b0};
        ge       = rem2 >= {1'b0, r_den};
        rem_diff = rem2 - {1'b0, r_den};
        sq_bit   = 32'd1 << (5'd30 - {r_cnt, 1'b0});
        trial    = r_res + sq_bit;
        mup      = r_up * r_fs;
        open_sat = (i_open > Q16_ONE) ? Q16_ONE : i_open;
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_done <= 1'b0;
                        r_cnt  <= '0;
                        if (i_up == '0 || i_down >= i_up) begin
                            r_state <= S_MUP;
                        end else begin
                            r_state <= S_DIVR;
                        end
                    end
                end
                S_DIVR: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_cnt   <= '0;
                    r_state <= (r_q <= i_crit) ? S_MUP : S_DIVX;
                end
                S_DIVX: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= S_SQR;
                    end
                end
                S_SQR: begin
                    r_cnt   <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= S_MFS;
                    end
                end
                S_MFS: r_state <= S_MUP;
                S_MUP: r_state <= S_MOP;
                S_MOP: r_state <= S_SUM;
                S_SUM: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_up   <= i_up;
                    r_den  <= i_up;
                    r_rem  <= i_down;
                    r_q    <= '0;
                    r_fs   <= '0;
                    r_open <= open_sat;
                end
            end
            S_DIVR, S_DIVX: begin
                r_rem <= ge ? rem_diff[UP_BITS-1:0] : rem2[UP_BITS-1:0];
                r_q   <= {r_q[14:0], ge};
            end
            S_CHK: begin
                r_fs  <= {i_coef, 16'h0000};
                r_rem <= UP_BITS'(17'({1'b0, r_q}) - 17'({1'b0, i_crit}));
                r_den <= UP_BITS'(Q16_ONE - 17'({1'b0, i_crit}));
                r_q   <= '0;
            end
            S_SQR: begin
                r_sq  <= 32'(33'h1_0000_0000 - 33'(r_q * r_q));
                r_res <= '0;
            end
            S_ROOT: begin
                if (r_sq >= trial) begin
                    r_sq  <= r_sq - trial;
                    r_res <= (r_res >> 1) + sq_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
            end
            S_MFS: r_fs <= i_coef * r_res[15:0];
            S_MUP: r_f  <= 48'(mup >> 16);
            S_MOP: begin
                r_p1 <= r_f[47:16] * r_open;
                r_p0 <= r_f[15:0] * r_open;
            end
            S_SUM: r_t <= 48'(r_p1 + 49'(r_p0[32:16]));
            default: ;
        endcase
    end

    assign o_res.done = r_done;
    assign o_res.term = r_t;

endmodule

// ===== sv/pneumatic_chamber_pressure_step.sv =====
`timescale 1ns / 1ps
// Top level: config registers, two valve lanes and the merge and update stage.
// Depends on pcps_pkg and pcps_valve_lane.
//
//  channel | direction | handshake              | payload
//  in      | sink      | i_in_valid/o_in_ready  | i_in  (t_in_beat)
//  out     | source    | o_out_valid/i_out_ready| o_out (t_out_beat)
//  cfg     | sink      | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// With either valve subsonic its lane sequencer runs two 16-step restoring
// divides and a 16-step square root, then three multiply steps and a sum, and
// the merge runs its multiply, sum and output stages. A choked valve skips the
// second divide, the square root and the first multiply; at zero flow a lane
// also skips the first divide.
// Reset loads the default registers and the initial pressure. A stalled
// output holds its beat; the next item is taken once the update is done.
module pneumatic_chamber_pressure_step #(
    parameter int PRESSURE_BITS = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  pcps_pkg::t_in_beat   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output pcps_pkg::t_out_beat  o_out,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [19:0]          i_cfg_data
);
    import pcps_pkg::*;

    localparam int UP_BITS = (PRESSURE_BITS > 20) ? PRESSURE_BITS : 20;
    localparam int SUM_BITS = ((PRESSURE_BITS > 33) ? PRESSURE_BITS : 33) + 1;
    localparam logic [PRESSURE_BITS-1:0] PMAX = '1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [15:0]              r_crit;
    logic [15:0]              r_coef;
    logic [15:0]              r_gain;
    logic [19:0]              r_supply;
    logic [19:0]              r_atm;
    logic [PRESSURE_BITS-1:0] r_p;
    logic [2:0]               r_state;
    logic                     r_neg;
    logic [47:0]              r_mag;
    logic [47:0]              r_mhi;
    logic [31:0]              r_mlo;
    logic [32:0]              r_dmag;
    logic                     r_out_valid;
    t_out_beat                r_out;

    logic                     in_fire;
    logic                     lane_start;
    t_lane_res                res_in;
    t_lane_res                res_out;
    logic [63:0]              prod;
    logic [SUM_BITS-1:0]      up_sum;
    logic [PRESSURE_BITS-1:0] n_p;
    logic                     n_clip;
    logic [UP_BITS-1:0]       init_ext;
    logic [PRESSURE_BITS-1:0] init_clamp;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign lane_start = in_fire;

    // inlet lane: supply into chamber
    pcps_valve_lane #(.UP_BITS(UP_BITS)) u_lane_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lane_start),
        .i_up    (UP_BITS'(r_supply)),
        .i_down  (UP_BITS'(r_p)),
        .i_open  (i_in.inlet_opening),
        .i_crit  (r_crit),
        .i_coef  (r_coef),
        .o_res   (res_in)
    );

    // outlet lane: chamber to atmosphere
    pcps_valve_lane #(.UP_BITS(UP_BITS)) u_lane_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lane_start),
        .i_up    (UP_BITS'(r_p)),
        .i_down  (UP_BITS'(r_atm)),
        .i_open  (i_in.outlet_opening),
        .i_crit  (r_crit),
        .i_coef  (r_coef),
        .o_res   (res_out)
    );

    // round the step, apply it and saturate
    always_comb begin
        prod     = {r_mhi, 16'h0000} + 64'(r_mlo);
        up_sum   = SUM_BITS'(r_p) + SUM_BITS'(r_dmag);
        init_ext = UP_BITS'(i_cfg_data);
        init_clamp = (init_ext > UP_BITS'(PMAX)) ? PMAX : PRESSURE_BITS'(init_ext);
        n_clip   = 1'b0;
        if (r_neg) begin
            if (SUM_BITS'(r_dmag) > SUM_BITS'(r_p)) begin
                n_p    = '0;
                n_clip = 1'b1;
            end else begin
                n_p = PRESSURE_BITS'(SUM_BITS'(r_p) - SUM_BITS'(r_dmag));
            end
        end else if (up_sum > SUM_BITS'(PMAX)) begin
            n_p    = PMAX;
            n_clip = 1'b1;
        end else begin
            n_p = PRESSURE_BITS'(up_sum);
        end
    end

    // merge sequencer and pressure state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_crit      <= 16'd19661;
            r_coef      <= 16'd1024;
            r_gain      <= 16'd4096;
            r_supply    <= 20'd600000;
            r_atm       <= 20'd101325;
            r_p         <= (UP_BITS'(20'd101325) > UP_BITS'(PMAX)) ?
                           PMAX : PRESSURE_BITS'(20'd101325);
        end else begin
            // drop the output beat once taken, unless a new one replaces it
            if (o_out_valid && i_out_ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            // take register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CRITICAL_RATIO:      r_crit   <= i_cfg_data[15:0];
                    CFG_FLOW_COEFFICIENT:    r_coef   <= i_cfg_data[15:0];
                    CFG_CHAMBER_GAIN:        r_gain   <= i_cfg_data[15:0];
                    CFG_SUPPLY_PRESSURE:     r_supply <= i_cfg_data;
                    CFG_ATMOSPHERE_PRESSURE: r_atm    <= i_cfg_data;
                    CFG_INITIAL_PRESSURE:    r_p      <= init_clamp;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (res_in.done && res_out.done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_SUM;
                S_SUM: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_p         <= n_p;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // merge datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_RUN: begin
                r_neg <= res_out.term > res_in.term;
                r_mag <= (res_out.term > res_in.term) ? res_out.term - res_in.term :
                                                        res_in.term - res_out.term;
            end
            S_MUL: begin
                r_mhi <= r_mag[47:16] * r_gain;
                r_mlo <= r_mag[15:0] * r_gain;
            end
            S_SUM: r_dmag <= 33'(prod[63:32]) + 33'(prod[31]);
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    r_out.chamber_pressure_out <= 20'(n_p);
                    r_out.pressure_clipped     <= n_clip;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // an accepted beat always starts the lanes
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state == S_RUN)
        else $error("accepted beat did not start the lanes");

    // pressure state never exceeds the saturation bound
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p <= PMAX)
        else $error("chamber pressure above bound");

    // a clipped result sits at one of the bounds
    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.pressure_clipped) |->
        (r_out.chamber_pressure_out == 20'(PMAX) || r_out.chamber_pressure_out == 20'd0))
        else $error("clipped flag without a bound value");

endmodule
